// ----- hw/rtl/i2c_master_checksum_transaction_assert.svh -----
// ----------------------------------------------------------------------------
// I2C master checksum transaction assertion macros
// Shared concurrent assertion forms for the transaction controller.
// ----------------------------------------------------------------------------
`ifndef I2C_MASTER_CHECKSUM_TRANSACTION_ASSERT_SVH
`define I2C_MASTER_CHECKSUM_TRANSACTION_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define I2CMC_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("i2cmc assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define I2CMC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("i2cmc assertion failed");

`endif

// ----- hw/rtl/i2cmc_pkg.sv -----
// ----------------------------------------------------------------------------
// I2C master checksum transaction package
// Types and fixed constants shared by the transaction controller modules.
// ----------------------------------------------------------------------------
package i2cmc_pkg;

    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned IDX_W   = 4;
    localparam int unsigned COUNT_W = 5;
    localparam int unsigned READ_BIT = 0;

    typedef enum logic [2:0] {
        OP_START = 3'd0,
        OP_LOAD  = 3'd1,
        OP_EVENT = 3'd2,
        OP_READ  = 3'd3,
        OP_MODE  = 3'd4
    } t_opcode;

    typedef enum logic [2:0] {
        PH_IDLE  = 3'd0,
        PH_ADDR  = 3'd1,
        PH_SEND  = 3'd2,
        PH_SSUM  = 3'd3,
        PH_RECV  = 3'd4,
        PH_RSUM  = 3'd5,
        PH_CB    = 3'd6,
        PH_SLAVE = 3'd7
    } t_phase;

    typedef enum logic [2:0] {
        ACT_NONE = 3'd0,
        ACT_TX   = 3'd1,
        ACT_RX   = 3'd2,
        ACT_ACK  = 3'd3,
        ACT_NACK = 3'd4
    } t_action;

    typedef enum logic [1:0] {
        ERR_NONE = 2'd0,
        ERR_SUM  = 2'd1,
        ERR_NACK = 2'd2
    } t_err;

    typedef struct packed {
        t_opcode              opcode;
        logic [BYTE_W-1:0]    target_address;
        logic [COUNT_W-1:0]   byte_count;
        logic [IDX_W-1:0]     buffer_index;
        logic [BYTE_W-1:0]    byte_value;
        logic                 rx_ready;
        logic [BYTE_W-1:0]    rx_byte;
        logic                 byte_nacked;
        logic                 master_mode;
    } t_cmd;

    typedef struct packed {
        t_action              bus_action;
        logic [BYTE_W-1:0]    tx_byte;
        logic                 callback_request;
        t_err                 error_code;
        t_phase               phase;
        logic [BYTE_W-1:0]    read_value;
        logic                 slave_mode;
    } t_result;

endpackage

// ----- hw/rtl/i2cmc_ram.sv -----
// ----------------------------------------------------------------------------
// I2C master checksum transaction buffer RAM
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module i2cmc_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 16
) (
    input  logic                                    i_clk,
    input  logic                                    i_wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]                        i_wr_data,
    input  logic                                    i_rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]                        o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ----- hw/rtl/i2cmc_ctrl.sv -----
// ----------------------------------------------------------------------------
// I2C master checksum transaction sequencer
// Message state, checksum and phase machine; forms one result per word.
// ----------------------------------------------------------------------------
module i2cmc_ctrl #(
    parameter int unsigned MSG_BYTES = 16
) (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    i_fire,
    input  i2cmc_pkg::t_cmd                         i_cmd,
    input  logic [i2cmc_pkg::BYTE_W-1:0]            i_buf_data,
    output i2cmc_pkg::t_result                      o_result,
    output logic [$clog2(MSG_BYTES+1)-1:0]          o_next_position,
    output logic                                    o_wr_en,
    output logic [((MSG_BYTES > 1) ? $clog2(MSG_BYTES) : 1)-1:0] o_wr_addr,
    output logic [i2cmc_pkg::BYTE_W-1:0]            o_wr_data
);

    localparam int unsigned LW = $clog2(MSG_BYTES + 1);
    localparam int unsigned AW = (MSG_BYTES > 1) ? $clog2(MSG_BYTES) : 1;

    i2cmc_pkg::t_phase              r_phase,    n_phase;
    logic [LW-1:0]                  r_position, n_position;
    logic [i2cmc_pkg::BYTE_W-1:0]   r_sum,      n_sum;
    logic [i2cmc_pkg::BYTE_W-1:0]   r_address,  n_address;
    logic [LW-1:0]                  r_length,   n_length;
    i2cmc_pkg::t_err                r_error,    n_error;
    logic                           r_slave,    n_slave;

    logic [i2cmc_pkg::BYTE_W-1:0]   w_neg_sum;
    logic [LW:0]                    w_pos_inc;
    logic                           w_last;
    logic                           w_idx_ok;
    logic [LW-1:0]                  w_count;

    assign w_neg_sum = {i2cmc_pkg::BYTE_W{1'b0}} - r_sum;
    assign w_pos_inc = {1'b0, r_position} + (LW+1)'(1);
    assign w_last    = w_pos_inc >= {1'b0, r_length};
    assign w_idx_ok  = 32'(i_cmd.buffer_index) < MSG_BYTES;

    always_comb begin
        if (i_cmd.byte_count == '0) begin
            w_count = LW'(1);
        end else if (32'(i_cmd.byte_count) > MSG_BYTES) begin
            w_count = LW'(MSG_BYTES);
        end else begin
            w_count = LW'(i_cmd.byte_count);
        end
    end

    // Next state.
    always_comb begin
        n_phase    = r_phase;
        n_position = r_position;
        n_sum      = r_sum;
        n_address  = r_address;
        n_length   = r_length;
        n_error    = r_error;
        n_slave    = r_slave;
        if (i_fire) begin
            case (i_cmd.opcode)
                i2cmc_pkg::OP_START: begin
                    if (!r_slave) begin
                        n_address  = i_cmd.target_address;
                        n_length   = w_count;
                        n_position = '0;
                        n_sum      = '0;
                        n_error    = i2cmc_pkg::ERR_NONE;
                        n_phase    = i2cmc_pkg::PH_ADDR;
                    end
                end
                i2cmc_pkg::OP_EVENT: begin
                    case (r_phase)
                        i2cmc_pkg::PH_ADDR: begin
                            n_phase = r_address[i2cmc_pkg::READ_BIT] ?
                                      i2cmc_pkg::PH_RECV : i2cmc_pkg::PH_SEND;
                        end
                        i2cmc_pkg::PH_SEND: begin
                            n_sum      = r_sum + i_buf_data;
                            n_position = LW'(w_pos_inc);
                            if (w_last) begin
                                n_phase = i2cmc_pkg::PH_SSUM;
                            end
                        end
                        i2cmc_pkg::PH_SSUM: begin
                            n_sum   = w_neg_sum;
                            n_phase = i2cmc_pkg::PH_CB;
                        end
                        i2cmc_pkg::PH_RECV: begin
                            if (i_cmd.rx_ready) begin
                                n_sum      = r_sum + i_cmd.rx_byte;
                                n_position = LW'(w_pos_inc);
                                if (w_last) begin
                                    n_phase = i2cmc_pkg::PH_RSUM;
                                end
                            end
                        end
                        i2cmc_pkg::PH_RSUM: begin
                            if (i_cmd.rx_ready) begin
                                n_sum   = w_neg_sum;
                                n_phase = i2cmc_pkg::PH_CB;
                                n_error = (i_cmd.rx_byte == w_neg_sum) ?
                                          i2cmc_pkg::ERR_NONE : i2cmc_pkg::ERR_SUM;
                            end
                        end
                        i2cmc_pkg::PH_CB: begin
                            if (i_cmd.byte_nacked) begin
                                n_error = i2cmc_pkg::ERR_NACK;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
                i2cmc_pkg::OP_MODE: begin
                    n_slave = !i_cmd.master_mode;
                    n_phase = i_cmd.master_mode ? i2cmc_pkg::PH_IDLE : i2cmc_pkg::PH_SLAVE;
                end
                default: begin
                end
            endcase
        end
    end

    // Outputs.
    always_comb begin
        o_result                  = '0;
        o_result.bus_action       = i2cmc_pkg::ACT_NONE;
        o_result.error_code       = n_error;
        o_result.phase            = n_phase;
        o_result.slave_mode       = n_slave;
        o_wr_en                   = 1'b0;
        o_wr_addr                 = AW'(i_cmd.buffer_index);
        o_wr_data                 = i_cmd.byte_value;
        case (i_cmd.opcode)
            i2cmc_pkg::OP_LOAD: begin
                o_wr_en = i_fire && w_idx_ok;
            end
            i2cmc_pkg::OP_EVENT: begin
                case (r_phase)
                    i2cmc_pkg::PH_ADDR: begin
                        o_result.bus_action = i2cmc_pkg::ACT_TX;
                        o_result.tx_byte    = r_address;
                    end
                    i2cmc_pkg::PH_SEND: begin
                        o_result.bus_action = i2cmc_pkg::ACT_TX;
                        o_result.tx_byte    = i_buf_data;
                    end
                    i2cmc_pkg::PH_SSUM: begin
                        o_result.bus_action = i2cmc_pkg::ACT_TX;
                        o_result.tx_byte    = w_neg_sum;
                    end
                    i2cmc_pkg::PH_RECV: begin
                        if (i_cmd.rx_ready) begin
                            o_result.bus_action = i2cmc_pkg::ACT_ACK;
                            o_wr_en             = i_fire;
                            o_wr_addr           = AW'(r_position);
                            o_wr_data           = i_cmd.rx_byte;
                        end else begin
                            o_result.bus_action = i2cmc_pkg::ACT_RX;
                        end
                    end
                    i2cmc_pkg::PH_RSUM: begin
                        o_result.bus_action = i_cmd.rx_ready ?
                                              i2cmc_pkg::ACT_NACK : i2cmc_pkg::ACT_RX;
                    end
                    i2cmc_pkg::PH_CB: begin
                        o_result.callback_request = 1'b1;
                    end
                    default: begin
                    end
                endcase
            end
            i2cmc_pkg::OP_READ: begin
                o_result.read_value = w_idx_ok ? i_buf_data : '0;
            end
            default: begin
            end
        endcase
    end

    assign o_next_position = n_position;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= i2cmc_pkg::PH_SLAVE;
            r_position <= '0;
            r_sum      <= '0;
            r_address  <= '0;
            r_length   <= LW'(1);
            r_error    <= i2cmc_pkg::ERR_NONE;
            r_slave    <= 1'b1;
        end else begin
            r_phase    <= n_phase;
            r_position <= n_position;
            r_sum      <= n_sum;
            r_address  <= n_address;
            r_length   <= n_length;
            r_error    <= n_error;
            r_slave    <= n_slave;
        end
    end

endmodule

// ----- hw/rtl/i2c_master_checksum_transaction.sv -----
// ----------------------------------------------------------------------------
// I2C master checksum transaction controller
// Sequences one I2C master message with a trailing byte checksum.
// ----------------------------------------------------------------------------
// Each input word is a command: start a message, load or read a buffer byte,
// report a bus event, or select master or slave mode. Every command gives
// exactly one result word carrying the bus action, the byte to send, the
// callback request, the error code, the phase and any buffer read value.
// The input channel uses i_valid and o_stall, the output channel o_valid
// and i_stall; a word moves when valid is high and stall is low.
// A command is registered on acceptance together with the buffer read it
// needs, and its result is registered in the result register when the
// command fires, which waits while the receiver stalls a held result word.
// o_valid rises once the result register is loaded. A new command is taken
// in every cycle while o_stall is low, one word per cycle sustained while
// the receiver does not stall.
// Reset starts the block in slave mode with an empty pipeline and holds
// o_stall high; the message buffer holds no defined data until loaded. While
// the receiver stalls, the result register holds its word and one further
// command may wait in the command register; only then does o_stall rise.
// ----------------------------------------------------------------------------
`include "i2c_master_checksum_transaction_assert.svh"

module i2c_master_checksum_transaction #(
    parameter int unsigned MSG_BYTES = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_stall,
    input  logic [2:0]                          i_opcode,
    input  logic [i2cmc_pkg::BYTE_W-1:0]        i_target_address,
    input  logic [i2cmc_pkg::COUNT_W-1:0]       i_byte_count,
    input  logic [i2cmc_pkg::IDX_W-1:0]         i_buffer_index,
    input  logic [i2cmc_pkg::BYTE_W-1:0]        i_byte_value,
    input  logic                                i_rx_ready,
    input  logic [i2cmc_pkg::BYTE_W-1:0]        i_rx_byte,
    input  logic                                i_byte_nacked,
    input  logic                                i_master_mode,
    output logic                                o_valid,
    input  logic                                i_stall,
    output logic [2:0]                          o_bus_action,
    output logic [i2cmc_pkg::BYTE_W-1:0]        o_tx_byte,
    output logic                                o_callback_request,
    output logic [1:0]                          o_error_code,
    output logic [2:0]                          o_phase,
    output logic [i2cmc_pkg::BYTE_W-1:0]        o_read_value,
    output logic                                o_slave_mode
);

    localparam int unsigned LW = $clog2(MSG_BYTES + 1);
    localparam int unsigned AW = (MSG_BYTES > 1) ? $clog2(MSG_BYTES) : 1;

    logic                           r_cmd_valid;
    i2cmc_pkg::t_cmd                r_cmd;
    logic                           r_out_valid;
    i2cmc_pkg::t_result             r_result;
    logic                           r_fwd_hit;
    logic [i2cmc_pkg::BYTE_W-1:0]   r_fwd_data;

    logic                           w_accept;
    logic                           w_fire;
    i2cmc_pkg::t_cmd                w_cmd_in;
    i2cmc_pkg::t_result             w_result;
    logic [LW-1:0]                  w_next_position;
    logic                           w_wr_en;
    logic [AW-1:0]                  w_wr_addr;
    logic [i2cmc_pkg::BYTE_W-1:0]   w_wr_data;
    logic [AW-1:0]                  w_rd_addr;
    logic [i2cmc_pkg::BYTE_W-1:0]   w_ram_data;
    logic [i2cmc_pkg::BYTE_W-1:0]   w_buf_data;

    assign w_fire   = r_cmd_valid && (!r_out_valid || !i_stall);
    assign o_stall  = !i_rst_n || (r_cmd_valid && r_out_valid && i_stall);
    assign w_accept = i_valid && !o_stall;

    always_comb begin
        w_cmd_in.opcode         = i2cmc_pkg::t_opcode'(i_opcode);
        w_cmd_in.target_address = i_target_address;
        w_cmd_in.byte_count     = i_byte_count;
        w_cmd_in.buffer_index   = i_buffer_index;
        w_cmd_in.byte_value     = i_byte_value;
        w_cmd_in.rx_ready       = i_rx_ready;
        w_cmd_in.rx_byte        = i_rx_byte;
        w_cmd_in.byte_nacked    = i_byte_nacked;
        w_cmd_in.master_mode    = i_master_mode;
    end

    // A read op addresses its slot; anything else pre-fetches the byte at the
    // position the message will have once the word ahead has been processed.
    assign w_rd_addr = (w_cmd_in.opcode == i2cmc_pkg::OP_READ) ?
                       AW'(i_buffer_index) : AW'(w_next_position);

    i2cmc_ram #(
        .WIDTH (i2cmc_pkg::BYTE_W),
        .DEPTH (MSG_BYTES)
    ) u_buffer (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (w_wr_addr),
        .i_wr_data (w_wr_data),
        .i_rd_en   (w_accept),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_ram_data)
    );

    assign w_buf_data = r_fwd_hit ? r_fwd_data : w_ram_data;

    i2cmc_ctrl #(
        .MSG_BYTES (MSG_BYTES)
    ) u_ctrl (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_fire          (w_fire),
        .i_cmd           (r_cmd),
        .i_buf_data      (w_buf_data),
        .o_result        (w_result),
        .o_next_position (w_next_position),
        .o_wr_en         (w_wr_en),
        .o_wr_addr       (w_wr_addr),
        .o_wr_data       (w_wr_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cmd_valid <= 1'b0;
            r_out_valid <= 1'b0;
            r_fwd_hit   <= 1'b0;
        end else begin
            if (w_accept) begin
                r_cmd_valid <= 1'b1;
                r_fwd_hit   <= w_wr_en && (w_wr_addr == w_rd_addr);
            end else if (w_fire) begin
                r_cmd_valid <= 1'b0;
            end
            if (w_fire) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_cmd      <= w_cmd_in;
            r_fwd_data <= w_wr_data;
        end
        if (w_fire) begin
            r_result <= w_result;
        end
    end

    assign o_valid            = r_out_valid;
    assign o_bus_action       = r_result.bus_action;
    assign o_tx_byte          = r_result.tx_byte;
    assign o_callback_request = r_result.callback_request;
    assign o_error_code       = r_result.error_code;
    assign o_phase            = r_result.phase;
    assign o_read_value       = r_result.read_value;
    assign o_slave_mode       = r_result.slave_mode;

    `I2CMC_ASSERT_NOW(a_slave_phase, i_clk, i_rst_n, o_valid,
        ((o_phase == i2cmc_pkg::PH_SLAVE) == o_slave_mode))
    `I2CMC_ASSERT_NOW(a_tx_only_on_send, i_clk, i_rst_n,
        o_valid && (o_bus_action != i2cmc_pkg::ACT_TX), (o_tx_byte == '0))
    `I2CMC_ASSERT_NOW(a_callback_phase, i_clk, i_rst_n, o_valid && o_callback_request,
        (o_phase == i2cmc_pkg::PH_CB) && (o_bus_action == i2cmc_pkg::ACT_NONE))
    `I2CMC_ASSERT_NEXT(a_result_follows, i_clk, i_rst_n, w_fire, o_valid)

endmodule
